[rtl/core/dark_and_black_bounding_box_ratio_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounding box ratio core
// Clocked concurrent checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef DARK_AND_BLACK_BOUNDING_BOX_RATIO_CORE_ASSERT_SVH
`define DARK_AND_BLACK_BOUNDING_BOX_RATIO_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define DBBR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DBBR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DBBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dbbr_pkg.sv]
// ----------------------------------------------------------------------------
// dbbr_pkg
// Shared types and constants of the bounding box ratio core.
// ----------------------------------------------------------------------------
package dbbr_pkg;

   localparam int REG_W      = 13;
   localparam int CFG_DATA_W = 32;
   localparam int CFG_ADDR_W = 3;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic [7:0] LEVEL_WHITE = 8'd255;
   localparam logic [7:0] LEVEL_BLACK = 8'd0;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      E_LEFT   = 2'd0,
      E_TOP    = 2'd1,
      E_RIGHT  = 2'd2,
      E_BOTTOM = 2'd3
   } edge_sel_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/core/dbbr_div.sv]
// ----------------------------------------------------------------------------
// dbbr_div
// Restoring fraction divider: quotient = floor((numer << (Q_W-1)) / denom)
// for numer <= denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbbr_div #(
   parameter int NUM_W = 13,
   parameter int Q_W   = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_W-1:0]        numer,
   input  logic [NUM_W-1:0]        denom,
   output dbbr_pkg::div_stat_type  stat,
   output logic [Q_W-1:0]          quotient
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [NUM_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic             ge;
   logic [NUM_W:0]   diff;

   always_comb begin
      ge   = rem_ff >= {1'b0, den_ff};
      diff = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         rem_in   = {1'b0, numer};
         den_in   = denom;
         q_in     = '0;
         count_in = CNT_W'(Q_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shifted value fits
         rem_in   = {diff[NUM_W-1:0], 1'b0};
         q_in     = {q_ff[Q_W-2:0], ge};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

[rtl/core/dark_and_black_bounding_box_ratio_core.sv]
// Non-final pixel: accepted in ST_IDLE; req_ready stays high for the next one.
// Final pixel: the four ratios share one bit-per-cycle divider, each edge in turn
// going through ST_START and ST_WAIT; ST_STORE then loads the result register.
// A frame with no black pixel goes from ST_IDLE straight to ST_STORE. req_ready is low
// meanwhile, and longer while an earlier result still waits on rsp_ready.
// Synchronous active-high reset clears counters, boxes, handshake state and
// sets image_width to 640 and image_height to 480.
// ----------------------------------------------------------------------------
// dark_and_black_bounding_box_ratio_core
// Tracks the dark and black pixel bounding boxes of a frame and reports the
// black box edges as Q1.FRAC_BITS fractions of the dark box.
// ----------------------------------------------------------------------------
`include "dark_and_black_bounding_box_ratio_core_assert.svh"

module dark_and_black_bounding_box_ratio_core #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_pixel_level,
   input  logic                                 req_frame_end,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_no_black,
   output logic [FRAC_BITS:0]                   rsp_left_ratio,
   output logic [FRAC_BITS:0]                   rsp_top_ratio,
   output logic [FRAC_BITS:0]                   rsp_right_ratio,
   output logic [FRAC_BITS:0]                   rsp_bottom_ratio,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dbbr_pkg::CFG_ADDR_W-1:0]      csr_paddr,
   input  logic [dbbr_pkg::CFG_DATA_W-1:0]      csr_pwdata,
   output logic [dbbr_pkg::CFG_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW     = $clog2(MAX_DIM);
   localparam int NW     = CW + 1;
   localparam int QW     = FRAC_BITS + 1;
   localparam int REG_W  = dbbr_pkg::REG_W;
   localparam int DATA_W = dbbr_pkg::CFG_DATA_W;
   localparam int XW     = (REG_W > CW + 1) ? REG_W : CW + 1;
   localparam logic [CW-1:0] MIN_RESET = CW'(MAX_DIM - 1);
   localparam logic [QW-1:0] ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_STORE
   } state_type;

   state_type              state_ff, state_in;
   dbbr_pkg::edge_sel_type op_ff, op_in;

   logic [REG_W-1:0] width_ff, width_in;
   logic [REG_W-1:0] height_ff, height_in;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] dark_l_ff, dark_l_in, dark_t_ff, dark_t_in;
   logic [CW-1:0] dark_r_ff, dark_r_in, dark_b_ff, dark_b_in;
   logic [CW-1:0] black_l_ff, black_l_in, black_t_ff, black_t_in;
   logic [CW-1:0] black_r_ff, black_r_in, black_b_ff, black_b_in;
   logic          black_seen_ff, black_seen_in;

   logic [QW-1:0] work_ff [4];
   logic [QW-1:0] work_in [4];

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_no_black_ff, rsp_no_black_in;
   logic [QW-1:0] rsp_left_ff, rsp_left_in, rsp_top_ff, rsp_top_in;
   logic [QW-1:0] rsp_right_ff, rsp_right_in, rsp_bottom_ff, rsp_bottom_in;

   logic          csr_write;
   logic [XW-1:0] w_raw, h_raw, eff_w, eff_h, col_next, row_next;
   logic          accept, is_dark, is_black;

   logic [CW-1:0] edge_sel, start_sel, stop_sel;
   logic          guard;
   logic [NW-1:0] div_numer, div_denom;
   logic          div_start;
   logic [QW-1:0] div_quot;
   dbbr_pkg::div_stat_type div_stat;

   logic          rsp_zero, rsp_ordered, black_inside, frame_done;

   // ---------------------------------------------------------------- divider
   dbbr_div #(
      .NUM_W (NW),
      .Q_W   (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // operand select for the current edge
   always_comb begin
      case (op_ff)
         dbbr_pkg::E_LEFT: begin
            edge_sel = black_l_ff; start_sel = dark_l_ff; stop_sel = dark_r_ff;
         end
         dbbr_pkg::E_TOP: begin
            edge_sel = black_t_ff; start_sel = dark_t_ff; stop_sel = dark_b_ff;
         end
         dbbr_pkg::E_RIGHT: begin
            edge_sel = black_r_ff; start_sel = dark_l_ff; stop_sel = dark_r_ff;
         end
         dbbr_pkg::E_BOTTOM: begin
            edge_sel = black_b_ff; start_sel = dark_t_ff; stop_sel = dark_b_ff;
         end
         default: begin
            edge_sel = black_l_ff; start_sel = dark_l_ff; stop_sel = dark_r_ff;
         end
      endcase
      guard     = (edge_sel < start_sel) || (stop_sel < start_sel);
      div_numer = NW'(edge_sel) - NW'(start_sel) + NW'(1);
      div_denom = NW'(stop_sel) - NW'(start_sel) + NW'(1);
   end

   assign div_start = (state_ff == ST_START);

   // ---------------------------------------------------------------- next state
   always_comb begin
      csr_write = csr_psel && csr_penable && csr_pwrite;
      accept    = req_valid && req_ready;
      is_dark   = req_pixel_level != dbbr_pkg::LEVEL_WHITE;
      is_black  = req_pixel_level == dbbr_pkg::LEVEL_BLACK;

      w_raw = XW'(width_ff);
      h_raw = XW'(height_ff);
      eff_w = (w_raw == '0) ? XW'(1) : ((w_raw > XW'(MAX_DIM)) ? XW'(MAX_DIM) : w_raw);
      eff_h = (h_raw == '0) ? XW'(1) : ((h_raw > XW'(MAX_DIM)) ? XW'(MAX_DIM) : h_raw);
      col_next = XW'(col_ff) + XW'(1);
      row_next = XW'(row_ff) + XW'(1);

      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (dbbr_pkg::csr_index_type'(csr_paddr[2]))
            dbbr_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_pwdata[REG_W-1:0];
            dbbr_pkg::CSR_IMAGE_HEIGHT: height_in = csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end

      state_in      = state_ff;
      op_in         = op_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      dark_l_in     = dark_l_ff;
      dark_t_in     = dark_t_ff;
      dark_r_in     = dark_r_ff;
      dark_b_in     = dark_b_ff;
      black_l_in    = black_l_ff;
      black_t_in    = black_t_ff;
      black_r_in    = black_r_ff;
      black_b_in    = black_b_ff;
      black_seen_in = black_seen_ff;
      work_in       = work_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_no_black_in = rsp_no_black_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_bottom_in   = rsp_bottom_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_dark) begin
                  if (col_ff < dark_l_ff) dark_l_in = col_ff;
                  if (row_ff < dark_t_ff) dark_t_in = row_ff;
                  if (col_ff > dark_r_ff) dark_r_in = col_ff;
                  if (row_ff > dark_b_ff) dark_b_in = row_ff;
               end
               if (is_black) begin
                  if (col_ff < black_l_ff) black_l_in = col_ff;
                  if (row_ff < black_t_ff) black_t_in = row_ff;
                  if (col_ff > black_r_ff) black_r_in = col_ff;
                  if (row_ff > black_b_ff) black_b_in = row_ff;
                  black_seen_in = 1'b1;
               end
               if (req_frame_end) begin
                  col_in   = '0;
                  row_in   = '0;
                  op_in    = dbbr_pkg::E_LEFT;
                  state_in = black_seen_in ? ST_START : ST_STORE;
               end else if (col_next >= eff_w) begin
                  // wrap to the next row; hold on the last row
                  col_in = '0;
                  if (row_next < eff_h) row_in = row_next[CW-1:0];
               end else begin
                  col_in = col_next[CW-1:0];
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               work_in[op_ff] = guard ? '0 : div_quot;
               if (op_ff == dbbr_pkg::E_BOTTOM) begin
                  state_in = ST_STORE;
               end else begin
                  op_in    = dbbr_pkg::edge_sel_type'(2'(op_ff + 2'd1));
                  state_in = ST_START;
               end
            end
         end
         ST_STORE: begin
            // load the output register once it is free, then clear the frame
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_no_black_in = !black_seen_ff;
               rsp_left_in     = black_seen_ff ? work_ff[dbbr_pkg::E_LEFT]   : '0;
               rsp_top_in      = black_seen_ff ? work_ff[dbbr_pkg::E_TOP]    : '0;
               rsp_right_in    = black_seen_ff ? work_ff[dbbr_pkg::E_RIGHT]  : '0;
               rsp_bottom_in   = black_seen_ff ? work_ff[dbbr_pkg::E_BOTTOM] : '0;
               dark_l_in       = MIN_RESET;
               dark_t_in       = MIN_RESET;
               dark_r_in       = '0;
               dark_b_in       = '0;
               black_l_in      = MIN_RESET;
               black_t_in      = MIN_RESET;
               black_r_in      = '0;
               black_b_in      = '0;
               black_seen_in   = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= dbbr_pkg::E_LEFT;
         width_ff      <= dbbr_pkg::WIDTH_RESET;
         height_ff     <= dbbr_pkg::HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         dark_l_ff     <= MIN_RESET;
         dark_t_ff     <= MIN_RESET;
         dark_r_ff     <= '0;
         dark_b_ff     <= '0;
         black_l_ff    <= MIN_RESET;
         black_t_ff    <= MIN_RESET;
         black_r_ff    <= '0;
         black_b_ff    <= '0;
         black_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         dark_l_ff     <= dark_l_in;
         dark_t_ff     <= dark_t_in;
         dark_r_ff     <= dark_r_in;
         dark_b_ff     <= dark_b_in;
         black_l_ff    <= black_l_in;
         black_t_ff    <= black_t_in;
         black_r_ff    <= black_r_in;
         black_b_ff    <= black_b_in;
         black_seen_ff <= black_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      work_ff         <= work_in;
      rsp_no_black_ff <= rsp_no_black_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_bottom_ff   <= rsp_bottom_in;
   end

   // ---------------------------------------------------------------- outputs
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_no_black     = rsp_no_black_ff;
   assign rsp_left_ratio   = rsp_left_ff;
   assign rsp_top_ratio    = rsp_top_ff;
   assign rsp_right_ratio  = rsp_right_ff;
   assign rsp_bottom_ratio = rsp_bottom_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (dbbr_pkg::csr_index_type'(csr_paddr[2]) ==
                              dbbr_pkg::CSR_IMAGE_HEIGHT) ?
                             DATA_W'(height_ff) : DATA_W'(width_ff);

   // ---------------------------------------------------------------- checks
   assign rsp_zero     = (rsp_left_ff == '0) && (rsp_top_ff == '0) &&
                         (rsp_right_ff == '0) && (rsp_bottom_ff == '0);
   assign rsp_ordered  = (rsp_left_ff <= rsp_right_ff) && (rsp_top_ff <= rsp_bottom_ff) &&
                         (rsp_right_ff <= ONE_Q) && (rsp_bottom_ff <= ONE_Q);
   assign black_inside = (dark_l_ff <= black_l_ff) && (dark_t_ff <= black_t_ff) &&
                         (black_r_ff <= dark_r_ff) && (black_b_ff <= dark_b_ff);
   assign frame_done   = (state_ff == ST_START) || (state_ff == ST_STORE);

   `DBBR_ASSERT_IMPLY(a_busy_blocks_req, clock, reset, div_stat.busy, !req_ready, "busy ready")
   `DBBR_ASSERT_IMPLY(a_no_black_zero, clock, reset, rsp_valid_ff && rsp_no_black_ff, rsp_zero, "ratios")
   `DBBR_ASSERT_IMPLY(a_ratio_order, clock, reset, rsp_valid_ff && !rsp_no_black_ff, rsp_ordered, "order")
   `DBBR_ASSERT_IMPLY(a_black_in_dark, clock, reset, black_seen_ff, black_inside, "black box outside")
   `DBBR_ASSERT_NEXT(a_frame_end_leaves_idle, clock, reset, accept && req_frame_end, frame_done, "report")

endmodule

[tb/dark_and_black_bounding_box_ratio_core_tb.sv]
// ----------------------------------------------------------------------------
// Bounding box ratio core testbench
// Streams frames of pixel levels into the core and predicts, for each frame,
// the black box edges as Q1.16 fractions of the dark box (or the no-black
// flag). Results are checked field by field against the oldest prediction
// while both channels stall at random and the frame size registers change.
// ----------------------------------------------------------------------------
module dark_and_black_bounding_box_ratio_core_tb;

   localparam int MAX_DIM       = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int SETTLE_CYCLES = 4*(FRAC_BITS+3)+10;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int REG_W         = dbbr_pkg::REG_W;

   typedef struct packed {
      logic                 no_black;
      logic [FRAC_BITS:0]   left;
      logic [FRAC_BITS:0]   top;
      logic [FRAC_BITS:0]   right;
      logic [FRAC_BITS:0]   bottom;
   } ratio_set_type;

   typedef enum int {DARK_BOX = 0, BLACK_BOX = 1} box_kind_type;

   // Frame tracker: follows pixel position and both boxes, queues the ratios.
   class box_ratio_board;
      logic [REG_W-1:0] width_reg;
      logic [REG_W-1:0] height_reg;
      int unsigned      col;
      int unsigned      row;
      int unsigned      boxes[2][4];
      bit               black_seen;
      ratio_set_type    expected_ratios[$];
      int               mismatches;

      function new();
         width_reg  = dbbr_pkg::WIDTH_RESET;
         height_reg = dbbr_pkg::HEIGHT_RESET;
         mismatches = 0;
         clear_frame();
      endfunction

      function int unsigned effective(logic [REG_W-1:0] v);
         if (v < 1) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void clear_frame();
         col = 0;
         row = 0;
         black_seen = 0;
         for (int k = 0; k < 2; k++) begin
            boxes[k][dbbr_pkg::E_LEFT]   = MAX_DIM - 1;
            boxes[k][dbbr_pkg::E_TOP]    = MAX_DIM - 1;
            boxes[k][dbbr_pkg::E_RIGHT]  = 0;
            boxes[k][dbbr_pkg::E_BOTTOM] = 0;
         end
      endfunction

      function void set_dim(dbbr_pkg::csr_index_type idx, logic [REG_W-1:0] value);
         if (idx == dbbr_pkg::CSR_IMAGE_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function void widen(box_kind_type k);
         if (col < boxes[k][dbbr_pkg::E_LEFT])   boxes[k][dbbr_pkg::E_LEFT]   = col;
         if (row < boxes[k][dbbr_pkg::E_TOP])    boxes[k][dbbr_pkg::E_TOP]    = row;
         if (col > boxes[k][dbbr_pkg::E_RIGHT])  boxes[k][dbbr_pkg::E_RIGHT]  = col;
         if (row > boxes[k][dbbr_pkg::E_BOTTOM]) boxes[k][dbbr_pkg::E_BOTTOM] = row;
      endfunction

      function logic [FRAC_BITS:0] fraction(int unsigned e, int unsigned lo, int unsigned hi);
         longint unsigned num;
         longint unsigned den;
         if (e < lo || hi < lo) return '0;
         num = longint'(e) - longint'(lo) + 1;
         den = longint'(hi) - longint'(lo) + 1;
         return (FRAC_BITS+1)'((num << FRAC_BITS) / den);
      endfunction

      function void note_pixel(logic [7:0] level, logic last);
         int unsigned   w;
         int unsigned   h;
         ratio_set_type r;
         w = effective(width_reg);
         h = effective(height_reg);
         if (level < dbbr_pkg::LEVEL_WHITE) widen(DARK_BOX);
         if (level == dbbr_pkg::LEVEL_BLACK) begin
            widen(BLACK_BOX);
            black_seen = 1;
         end
         if (!last) begin
            // wrap to the next row; hold on the last row once the frame is full
            if (col + 1 >= w) begin
               col = 0;
               if (row + 1 < h) row = row + 1;
            end else begin
               col = col + 1;
            end
            return;
         end
         r = '0;
         if (black_seen) begin
            r.left   = fraction(boxes[BLACK_BOX][dbbr_pkg::E_LEFT],
                                boxes[DARK_BOX][dbbr_pkg::E_LEFT],
                                boxes[DARK_BOX][dbbr_pkg::E_RIGHT]);
            r.top    = fraction(boxes[BLACK_BOX][dbbr_pkg::E_TOP],
                                boxes[DARK_BOX][dbbr_pkg::E_TOP],
                                boxes[DARK_BOX][dbbr_pkg::E_BOTTOM]);
            r.right  = fraction(boxes[BLACK_BOX][dbbr_pkg::E_RIGHT],
                                boxes[DARK_BOX][dbbr_pkg::E_LEFT],
                                boxes[DARK_BOX][dbbr_pkg::E_RIGHT]);
            r.bottom = fraction(boxes[BLACK_BOX][dbbr_pkg::E_BOTTOM],
                                boxes[DARK_BOX][dbbr_pkg::E_TOP],
                                boxes[DARK_BOX][dbbr_pkg::E_BOTTOM]);
         end else begin
            r.no_black = 1'b1;
         end
         expected_ratios.push_back(r);
         clear_frame();
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_ratios(ratio_set_type got);
         ratio_set_type want;
         if (expected_ratios.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_ratios.pop_front();
         compare("no_black", want.no_black, got.no_black);
         compare("left_ratio", want.left, got.left);
         compare("top_ratio", want.top, got.top);
         compare("right_ratio", want.right, got.right);
         compare("bottom_ratio", want.bottom, got.bottom);
      endfunction

      function int pending();
         return expected_ratios.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_pixel_level;
   logic                            req_frame_end;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_no_black;
   logic [FRAC_BITS:0]              rsp_left_ratio;
   logic [FRAC_BITS:0]              rsp_top_ratio;
   logic [FRAC_BITS:0]              rsp_right_ratio;
   logic [FRAC_BITS:0]              rsp_bottom_ratio;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dbbr_pkg::CFG_ADDR_W-1:0] csr_paddr;
   logic [dbbr_pkg::CFG_DATA_W-1:0] csr_pwdata;
   logic [dbbr_pkg::CFG_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   box_ratio_board board;
   int             req_idle_pct;
   int             rsp_idle_pct;

   dark_and_black_bounding_box_ratio_core #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_level  (req_pixel_level),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_no_black     (rsp_no_black),
      .rsp_left_ratio   (rsp_left_ratio),
      .rsp_top_ratio    (rsp_top_ratio),
      .rsp_right_ratio  (rsp_right_ratio),
      .rsp_bottom_ratio (rsp_bottom_ratio),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * 20);
      $display("TEST FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_ratios({rsp_no_black, rsp_left_ratio, rsp_top_ratio,
                             rsp_right_ratio, rsp_bottom_ratio});
   end

   task send_pixel(input logic [7:0] level, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_pixel_level = level;
      req_frame_end   = last;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(level, last);
   endtask

   // Drop valid, wait out every pending frame, then let the divider go idle.
   task quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_dim(input dbbr_pkg::csr_index_type idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {19'($urandom()), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_dim(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task set_frame(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
      quiesce();
      write_dim(dbbr_pkg::CSR_IMAGE_WIDTH, w);
      write_dim(dbbr_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [7:0] pick_level(bit black_ok);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return dbbr_pkg::LEVEL_WHITE;
      if (roll < 50) return black_ok ? dbbr_pkg::LEVEL_BLACK : 8'd254;
      if (roll < 58) return 8'd254;
      if (roll < 64) return 8'd1;
      return black_ok ? 8'($urandom_range(255)) : 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [REG_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'd8191;
         4:       return 13'($urandom_range(8191));
         default: return 13'($urandom_range(8, 1));
      endcase
   endfunction

   task send_frame(input int unsigned len, input bit black_ok);
      for (int unsigned i = 0; i < len; i++)
         send_pixel(pick_level(black_ok), i == len - 1);
   endtask

   initial begin
      int unsigned area;
      int unsigned len;
      int unsigned sent;
      int unsigned roll;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_level = '0;
      req_frame_end   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_idle_pct    = 25;
      rsp_idle_pct    = 62;
      board           = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-white frame, dark without black, lone black pixel
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b1);
      send_pixel(8'd77, 1'b0);
      send_pixel(8'd254, 1'b1);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b1);

      // 3x2 frame overrun by two pixels: last row absorbs the extra
      set_frame(13'd3, 13'd2);
      send_pixel(8'd128, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b0);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd10, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b0);
      send_pixel(8'd200, 1'b1);

      // zero width acts as one, oversize height clamps
      set_frame('0, 13'd8191);
      send_pixel(8'd254, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b0);
      send_pixel(8'd1, 1'b1);

      // shrink the width in the middle of a frame
      set_frame(13'd5, 13'd4);
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_WHITE, 1'b0);
      quiesce();
      write_dim(dbbr_pkg::CSR_IMAGE_WIDTH, 13'd2);
      send_pixel(8'd200, 1'b0);
      send_pixel(dbbr_pkg::LEVEL_BLACK, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 62 : 0;
         rsp_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 25 : 0;
         for (int setting = 0; setting < 4; setting++) begin
            set_frame(pick_dim(), pick_dim());
            area = board.effective(board.width_reg) * board.effective(board.height_reg);
            sent = 0;
            while (sent < 24) begin
               roll = $urandom_range(99);
               if (area > 44)
                  len = $urandom_range(44, 1);
               else if (roll < 60)
                  len = area;
               else if (roll < 85)
                  len = $urandom_range(area, 1);
               else
                  len = area + $urandom_range(4, 1);
               send_frame(len, $urandom_range(4) != 0);
               sent += len;
            end
         end
      end

      quiesce();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
